### rtl/box_downsample_2x2_defines.svh
// Assertion helpers shared by the downsampler RTL.
`ifndef BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define BD2_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bd2 check failed");

// Next-cycle implication, checked on clk_i outside reset.
`define BD2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bd2 check failed");

`endif

### rtl/bd2_pkg.sv
package bd2_pkg;

  localparam int ColW       = 12;
  localparam int RowW       = 16;
  localparam int NchW       = 3;
  localparam int ChanW      = 8;
  localparam int PairW      = ChanW + 1;
  localparam int NumChan    = 4;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam int MaxWidthDef = 2048;
  localparam int MaxChanDef  = 4;

  localparam logic [ColW-1:0] WidthRst  = ColW'(2048);
  localparam logic [RowW-1:0] HeightRst = RowW'(2048);
  localparam logic [NchW-1:0] NchRst    = NchW'(4);

  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_CHANNELS = CfgIdxW'(2);

  typedef struct packed {
    logic hold;
    logic wr;
    logic rd;
  } lane_ctl_t;

endpackage

### rtl/bd2_lane.sv
module bd2_lane #(
  parameter int StoreDepth = bd2_pkg::MaxWidthDef / 2,
  parameter int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bd2_pkg::lane_ctl_t          ctl_i,
  input  logic [IdxW-1:0]             idx_i,
  input  logic [bd2_pkg::ChanW-1:0]   px_i,
  output logic [bd2_pkg::ChanW-1:0]   avg_o
);

  logic [bd2_pkg::ChanW-1:0] held_q;
  logic [bd2_pkg::PairW-1:0] pair;
  logic [bd2_pkg::PairW-1:0] sum_q;
  logic [bd2_pkg::PairW-1:0] rdata_q;
  logic [bd2_pkg::PairW:0]   total;
  logic [bd2_pkg::PairW-1:0] mem_q [StoreDepth];

  assign pair = bd2_pkg::PairW'(held_q) + bd2_pkg::PairW'(px_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (ctl_i.hold) begin
      held_q <= px_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[idx_i] <= pair;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[idx_i];
      sum_q   <= pair;
    end
  end

  assign total = (bd2_pkg::PairW+1)'(sum_q) + (bd2_pkg::PairW+1)'(rdata_q);
  assign avg_o = total[bd2_pkg::PairW:2];

endmodule

### rtl/bd2_ctrl.sv
module bd2_ctrl #(
  parameter int MaxWidth   = bd2_pkg::MaxWidthDef,
  parameter int MaxChan    = bd2_pkg::MaxChanDef,
  parameter int StoreDepth = MaxWidth / 2,
  parameter int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [bd2_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bd2_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          out_ready_i,
  output bd2_pkg::lane_ctl_t            lane_ctl_o,
  output logic [IdxW-1:0]               idx_o,
  output logic                          s1_valid_o,
  output logic                          s1_last_o,
  output logic [bd2_pkg::NchW-1:0]      nch_o
);

  localparam int ColW = bd2_pkg::ColW;
  localparam int RowW = bd2_pkg::RowW;

  logic [ColW-1:0]          width_q;
  logic [RowW-1:0]          height_q;
  logic [bd2_pkg::NchW-1:0] nch_q;
  logic [ColW-1:0]          col_q, col_d;
  logic [RowW-1:0]          row_q, row_d;
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_last_q, s1_last_d;
  logic [ColW-1:0]          w_eff;
  logic [RowW-1:0]          h_eff;
  logic [ColW-2:0]          half_col;
  logic                     acc;
  logic                     odd_col;
  logic                     odd_row;
  logic                     last_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bd2_pkg::WidthRst;
      height_q <= bd2_pkg::HeightRst;
      nch_q    <= bd2_pkg::NchRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bd2_pkg::CFG_WIDTH:    width_q  <= cfg_data_i[ColW-1:0];
        bd2_pkg::CFG_HEIGHT:   height_q <= cfg_data_i[RowW-1:0];
        bd2_pkg::CFG_CHANNELS: nch_q    <= cfg_data_i[bd2_pkg::NchW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = ColW'(1);
    end else if (int'(width_q) > MaxWidth) begin
      w_eff = ColW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q == '0) ? RowW'(1) : height_q;
    if (nch_q == '0) begin
      nch_o = bd2_pkg::NchW'(1);
    end else if (int'(nch_q) > MaxChan) begin
      nch_o = bd2_pkg::NchW'(MaxChan);
    end else begin
      nch_o = nch_q;
    end
  end

  assign in_stall_o = s1_valid_q && !out_ready_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign odd_col    = col_q[0];
  assign odd_row    = row_q[0];
  assign half_col   = col_q[ColW-1:1];

  always_comb begin
    if (int'(half_col) >= StoreDepth) begin
      idx_o = IdxW'(int'(half_col) - StoreDepth);
    end else begin
      idx_o = IdxW'(half_col);
    end
  end

  assign lane_ctl_o.hold = acc && !odd_col;
  assign lane_ctl_o.wr   = acc && odd_col && !odd_row;
  assign lane_ctl_o.rd   = acc && odd_col && odd_row;

  assign last_pix = ((ColW'(half_col) + ColW'(1)) == ColW'(w_eff[ColW-1:1]))
                 && ((RowW'(row_q[RowW-1:1]) + RowW'(1)) == RowW'(h_eff[RowW-1:1]));

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = s1_valid_q;
    s1_last_d  = s1_last_q;
    if (out_ready_i) begin
      s1_valid_d = 1'b0;
    end
    if (acc) begin
      s1_valid_d = odd_col && odd_row;
      s1_last_d  = last_pix;
      if (col_q >= w_eff - ColW'(1)) begin
        col_d = '0;
        row_d = (row_q >= h_eff - RowW'(1)) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      s1_last_q  <= s1_last_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_last_o  = s1_last_q;

endmodule

### rtl/bd2_merge.sv
module bd2_merge #(
  parameter int MaxChan = bd2_pkg::MaxChanDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s1_valid_i,
  input  logic                                    s1_last_i,
  input  logic [bd2_pkg::NchW-1:0]                nch_i,
  input  logic [MaxChan-1:0][bd2_pkg::ChanW-1:0]  avg_i,
  input  logic                                    out_stall_i,
  output logic                                    out_ready_o,
  output logic                                    out_valid_o,
  output logic [bd2_pkg::NumChan-1:0][bd2_pkg::ChanW-1:0] chan_o,
  output logic                                    frame_last_o
);

  logic                                           valid_q;
  logic [bd2_pkg::NumChan-1:0][bd2_pkg::ChanW-1:0] chan_q, chan_d;
  logic                                           last_q;

  assign out_ready_o = !valid_q || !out_stall_i;

  for (genvar c = 0; c < bd2_pkg::NumChan; c++) begin : g_chan
    if (c < MaxChan) begin : g_used
      assign chan_d[c] = (int'(nch_i) > c) ? avg_i[c] : '0;
    end else begin : g_zero
      assign chan_d[c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_ready_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_o && s1_valid_i) begin
      chan_q <= chan_d;
      last_q <= s1_last_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign chan_o       = chan_q;
  assign frame_last_o = last_q;

endmodule

### rtl/box_downsample_2x2.sv
// 2x2 box-filter mip downsampler. Pixels enter one per clock unless stalled,
// in raster order, up to four 8-bit channels each; every 2x2 block gives one
// output pixel whose channels are the block sum divided by 4, truncated, with
// channels at or above channel_count forced to zero and frame_last set on the
// frame's final output. An odd last column or row is dropped. An odd row's
// odd-column pixel completes its block; the result is registered in lanes, then
// in bd2_merge. Each channel lane owns a MAX_WIDTH/2-entry line store of 9-bit
// pair sums with one write or one read per cycle, so the line store sets the
// single-cycle rate. The store needs no clearing after reset. Configure width,
// height and channel count only while no transfer is in flight.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH    = bd2_pkg::MaxWidthDef,
  parameter int MAX_CHANNELS = bd2_pkg::MaxChanDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bd2_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bd2_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bd2_pkg::ChanW-1:0]     chan0_in_i,
  input  logic [bd2_pkg::ChanW-1:0]     chan1_in_i,
  input  logic [bd2_pkg::ChanW-1:0]     chan2_in_i,
  input  logic [bd2_pkg::ChanW-1:0]     chan3_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bd2_pkg::ChanW-1:0]     chan0_out_o,
  output logic [bd2_pkg::ChanW-1:0]     chan1_out_o,
  output logic [bd2_pkg::ChanW-1:0]     chan2_out_o,
  output logic [bd2_pkg::ChanW-1:0]     chan3_out_o,
  output logic                          frame_last_o
);

`include "box_downsample_2x2_defines.svh"

  localparam int StoreDepth = MAX_WIDTH / 2;
  localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  bd2_pkg::lane_ctl_t                               lane_ctl;
  logic [IdxW-1:0]                                  idx;
  logic                                             s1_valid;
  logic                                             s1_last;
  logic                                             out_ready;
  logic [bd2_pkg::NchW-1:0]                         nch;
  logic [bd2_pkg::NumChan-1:0][bd2_pkg::ChanW-1:0]  px;
  logic [MAX_CHANNELS-1:0][bd2_pkg::ChanW-1:0]      avg;
  logic [bd2_pkg::NumChan-1:0][bd2_pkg::ChanW-1:0]  chan_out;

  assign cfg_ready_o = 1'b1;
  assign px = {chan3_in_i, chan2_in_i, chan1_in_i, chan0_in_i};

  bd2_ctrl #(
    .MaxWidth   (MAX_WIDTH),
    .MaxChan    (MAX_CHANNELS),
    .StoreDepth (StoreDepth),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_ready_i (out_ready),
    .lane_ctl_o  (lane_ctl),
    .idx_o       (idx),
    .s1_valid_o  (s1_valid),
    .s1_last_o   (s1_last),
    .nch_o       (nch)
  );

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    bd2_lane #(
      .StoreDepth (StoreDepth),
      .IdxW       (IdxW)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl),
      .idx_i  (idx),
      .px_i   (px[c]),
      .avg_o  (avg[c])
    );
  end

  bd2_merge #(
    .MaxChan (MAX_CHANNELS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .s1_last_i    (s1_last),
    .nch_i        (nch),
    .avg_i        (avg),
    .out_stall_i  (out_stall_i),
    .out_ready_o  (out_ready),
    .out_valid_o  (out_valid_o),
    .chan_o       (chan_out),
    .frame_last_o (frame_last_o)
  );

  assign chan0_out_o = chan_out[0];
  assign chan1_out_o = chan_out[1];
  assign chan2_out_o = chan_out[2];
  assign chan3_out_o = chan_out[3];

  `BD2_ASSERT_IMPL(a_stall_needs_full, in_stall_o, out_valid_o && s1_valid)
  `BD2_ASSERT_NEXT(a_read_fills_stage, lane_ctl.rd, s1_valid)
  `BD2_ASSERT_NEXT(a_stage_drains, s1_valid && !out_valid_o, out_valid_o)

endmodule

### tb/tb_box_downsample_2x2.sv
module tb_box_downsample_2x2;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ColW        = bd2_pkg::ColW;
  localparam int RowW        = bd2_pkg::RowW;
  localparam int NchW        = bd2_pkg::NchW;
  localparam int ChanW       = bd2_pkg::ChanW;
  localparam int PairW       = bd2_pkg::PairW;
  localparam int NumChan     = bd2_pkg::NumChan;
  localparam int CfgIdxW     = bd2_pkg::CfgIdxW;
  localparam int CfgDataW    = bd2_pkg::CfgDataW;
  localparam int MaxWidthDef = bd2_pkg::MaxWidthDef;
  localparam int MaxChanDef  = bd2_pkg::MaxChanDef;

  localparam logic [ColW-1:0]    WidthRst     = bd2_pkg::WidthRst;
  localparam logic [RowW-1:0]    HeightRst    = bd2_pkg::HeightRst;
  localparam logic [NchW-1:0]    NchRst       = bd2_pkg::NchRst;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = bd2_pkg::CFG_WIDTH;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = bd2_pkg::CFG_HEIGHT;
  localparam logic [CfgIdxW-1:0] CFG_CHANNELS = bd2_pkg::CFG_CHANNELS;

  localparam int RandItems  = 550;
  localparam int CycleLimit = 600000;
  localparam int StoreDepth = MaxWidthDef / 2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CfgIdxW'(3);

  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

  typedef struct packed {
    pixel_t chan;
    logic   last;
  } mip_px_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    pixel_t              px;
    logic                typed;
    mip_px_t             want;
  } dir_row_t;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_PULSED
  } drain_mode_e;

  localparam dir_row_t DirRows [33] = '{
    '{1'b1, CFG_WIDTH,    16'd2,      '0,           1'b0, '0},
    '{1'b1, CFG_HEIGHT,   16'd2,      '0,           1'b0, '0},
    '{1'b1, CFG_CHANNELS, 16'd4,      '0,           1'b0, '0},
    '{1'b0, '0,           '0,         32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hFFFFFFFF, 1'b1, {32'hFFFFFFFF, 1'b1}},
    '{1'b0, '0,           '0,         32'h80FF0003, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h80FF0000, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h81FF0300, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h80FF0000, 1'b1, {32'h80FF0000, 1'b1}},
    '{1'b1, CFG_CHANNELS, 16'd0,      '0,           1'b0, '0},
    '{1'b0, '0,           '0,         32'hC8C8C8C8, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hC8C8C8C8, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hC8C8C8C8, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hC8C8C8C8, 1'b1, {32'h000000C8, 1'b1}},
    '{1'b1, CFG_CHANNELS, 16'hFFFF,   '0,           1'b0, '0},
    '{1'b1, CFG_WIDTH,    16'hF003,   '0,           1'b0, '0},
    '{1'b1, CFG_HEIGHT,   16'd3,      '0,           1'b0, '0},
    '{1'b0, '0,           '0,         32'h01020304, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h05060708, 1'b0, '0},
    '{1'b0, '0,           '0,         32'hFFFFFFFF, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h10203040, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h50607080, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h00000000, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h11111111, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h22222222, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h33333333, 1'b0, '0},
    '{1'b1, CFG_WIDTH,    16'd0,      '0,           1'b0, '0},
    '{1'b1, CFG_HEIGHT,   16'd0,      '0,           1'b0, '0},
    '{1'b1, CFG_SPARE,    16'hFFFF,   '0,           1'b0, '0},
    '{1'b0, '0,           '0,         32'hA5A55A5A, 1'b0, '0},
    '{1'b0, '0,           '0,         32'h5A5AA5A5, 1'b0, '0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic [ChanW-1:0]    chan0_in_i  = '0;
  logic [ChanW-1:0]    chan1_in_i  = '0;
  logic [ChanW-1:0]    chan2_in_i  = '0;
  logic [ChanW-1:0]    chan3_in_i  = '0;
  logic                out_stall_i = 1'b0;
  logic                cfg_ready_o;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [ChanW-1:0]    chan0_out_o;
  logic [ChanW-1:0]    chan1_out_o;
  logic [ChanW-1:0]    chan2_out_o;
  logic [ChanW-1:0]    chan3_out_o;
  logic                frame_last_o;

  box_downsample_2x2 uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .chan0_in_i   (chan0_in_i),
    .chan1_in_i   (chan1_in_i),
    .chan2_in_i   (chan2_in_i),
    .chan3_in_i   (chan3_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chan0_out_o  (chan0_out_o),
    .chan1_out_o  (chan1_out_o),
    .chan2_out_o  (chan2_out_o),
    .chan3_out_o  (chan3_out_o),
    .frame_last_o (frame_last_o)
  );

  logic [NumChan-1:0][PairW-1:0] pair_sums [StoreDepth];
  pixel_t          held_px    = '0;
  logic [ColW-1:0] col_pos    = '0;
  logic [RowW-1:0] row_pos    = '0;
  logic [ColW-1:0] width_reg  = WidthRst;
  logic [RowW-1:0] height_reg = HeightRst;
  logic [NchW-1:0] chans_reg  = NchRst;

  mip_px_t     mip_q [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  int          cycles      = 0;
  drain_mode_e drain_mode  = DRAIN_FREE;
  int          drain_left  = 0;
  int          drain_phase = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MaxWidthDef) w = MaxWidthDef;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  function automatic bit mip_predict(input pixel_t px, output mip_px_t res);
    int              w;
    int              h;
    int              nch;
    int              idx;
    bit              made;
    logic [PairW-1:0] pair;
    logic [PairW:0]   total;
    w    = eff_width();
    h    = eff_height();
    nch  = (chans_reg == '0) ? 1 : (int'(chans_reg) > MaxChanDef ? MaxChanDef : int'(chans_reg));
    idx  = (int'(col_pos) >> 1) % StoreDepth;
    made = 1'b0;
    res  = '0;
    if (!col_pos[0]) begin
      held_px = px;
    end else begin
      for (int c = 0; c < NumChan; c++) begin
        pair = PairW'(held_px[c]) + PairW'(px[c]);
        if (!row_pos[0]) begin
          pair_sums[idx][c] = pair;
        end else begin
          total = (PairW+1)'(pair) + (PairW+1)'(pair_sums[idx][c]);
          res.chan[c] = (c < nch) ? total[PairW:2] : '0;
        end
      end
      if (row_pos[0]) begin
        res.last = (int'(col_pos) == (w / 2) * 2 - 1) && (int'(row_pos) == (h / 2) * 2 - 1);
        made = 1'b1;
      end
    end
    if (int'(col_pos) >= w - 1) begin
      col_pos = '0;
      if (int'(row_pos) >= h - 1) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return made;
  endfunction

  task automatic settle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (mip_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      CFG_WIDTH:    width_reg  = data[ColW-1:0];
      CFG_HEIGHT:   height_reg = data[RowW-1:0];
      CFG_CHANNELS: chans_reg  = data[NchW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed, input mip_px_t want);
    mip_px_t res;
    bit      taken;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    chan0_in_i <= px[0];
    chan1_in_i <= px[1];
    chan2_in_i <= px[2];
    chan3_in_i <= px[3];
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken && mip_predict(px, res)) mip_q.push_back(typed ? want : res);
      @(posedge clk_i);
    end while (!taken);
  endtask

  always @(posedge clk_i) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_e'($urandom_range(0, 2));
      drain_left = $urandom_range(16, 160);
    end
    drain_left--;
    drain_phase++;
    case (drain_mode)
      DRAIN_FREE:   out_stall_i <= 1'b0;
      DRAIN_RANDOM: out_stall_i <= 1'($urandom_range(0, 1));
      default:      out_stall_i <= (drain_phase % 4 != 0);
    endcase
  end

  always @(negedge clk_i) begin
    mip_px_t want;
    pixel_t  got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {chan3_out_o, chan2_out_o, chan1_out_o, chan0_out_o};
      if (mip_q.size() == 0) begin
        $error("unexpected output transfer: chan %h frame_last %0b", got, frame_last_o);
        mismatches++;
      end else begin
        want = mip_q.pop_front();
        for (int c = 0; c < NumChan; c++) begin
          if (got[c] !== want.chan[c]) begin
            $error("chan%0d_out: expected %0d, actual %0d", c, want.chan[c], got[c]);
            mismatches++;
          end
        end
        if (frame_last_o !== want.last) begin
          $error("frame_last: expected %0b, actual %0b", want.last, frame_last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    bit              cfg_open;
    bit              width_free;
    int              rand_items;
    int              count;
    int              w;
    int              h;
    int              pick;
    logic [ColW-1:0] wraw;
    logic [RowW-1:0] hraw;
    pixel_t          px;
    cfg_open   = 1'b0;
    rand_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirRows[i]) begin
      if (DirRows[i].is_cfg) begin
        if (!cfg_open) settle();
        cfg_write(DirRows[i].idx, DirRows[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        send_pixel(DirRows[i].px, DirRows[i].typed, DirRows[i].want);
      end
    end

    while (rand_items < RandItems) begin
      settle();
      // width may only move where the next row fills the line store
      width_free = (col_pos == '0) && !row_pos[0];
      if (width_free) begin
        pick = $urandom_range(0, 15);
        case (pick)
          0:       wraw = '0;
          1:       wraw = ColW'(1);
          2:       wraw = ColW'(2);
          default: wraw = ColW'($urandom_range(3, 12));
        endcase
      end else begin
        wraw = width_reg;
      end
      pick = $urandom_range(0, 15);
      case (pick)
        0:       hraw = '0;
        1:       hraw = RowW'(1);
        2:       hraw = '1;
        default: hraw = RowW'($urandom_range(2, 6));
      endcase
      cfg_write(CFG_WIDTH, {(CfgDataW-ColW)'($urandom), wraw});
      cfg_write(CFG_HEIGHT, hraw);
      cfg_write(CFG_CHANNELS, {(CfgDataW-NchW)'($urandom), NchW'($urandom_range(0, 7))});
      cfg_valid_i <= 1'b0;
      w = eff_width();
      h = eff_height();
      if (!width_free) count = w - int'(col_pos);
      else if (w * h <= 120 && $urandom_range(0, 3) != 0) count = w * h * $urandom_range(1, 3);
      else count = $urandom_range(1, 40);
      if (count > RandItems - rand_items) count = RandItems - rand_items;
      repeat (count) begin
        for (int c = 0; c < NumChan; c++) begin
          pick  = $urandom_range(0, 15);
          px[c] = (pick == 0) ? '0 : (pick == 1) ? '1 : ChanW'($urandom_range(0, 255));
        end
        send_pixel(px, 1'b0, '0);
        rand_items++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
